[src/baq_pkg.sv]
package baq_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_REP = 2'd0,
    OP_LOAD_VAR = 2'd1,
    OP_HEADER   = 2'd2,
    OP_SAMPLE   = 2'd3
  } op_t;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_INDEX = 2'd1;
  localparam logic [1:0] ERR_ZERO_SCALE = 2'd2;

  localparam logic [2:0] CFG_WORD_LENGTH = 3'd0;
  localparam logic [2:0] CFG_BLOCK_SIZE  = 3'd1;
  localparam logic [2:0] CFG_SEGMENTS    = 3'd2;
  localparam logic [2:0] CFG_LOW_POWER   = 3'd3;

  localparam int SCALE_W = 27;
  localparam int REP_W   = 15;
  localparam int VAR_W   = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_RD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] word_length_mode;
    logic [1:0] block_len_sel;
    logic       segment_count_mode;
    logic       low_power_flagging;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic hdr_set;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic div_last;
    logic out_free;
  } sts_t;

  // {negative, half-table entry} for one code
  function automatic logic [8:0] code_entry(input logic [7:0] code, input logic [2:0] mode);
    logic [7:0] half;
    logic [7:0] mask;
    logic [7:0] c;
    logic       neg;
    unique case (mode)
      3'd0:    half = 8'd2;
      3'd1:    half = 8'd4;
      3'd2:    half = 8'd8;
      3'd3:    half = 8'd32;
      default: half = 8'd128;
    endcase
    mask = 8'(half << 1) - 8'd1;
    c = code & mask;
    neg = c < half;
    return {neg, neg ? (half - 8'd1 - c) : (c - half)};
  endfunction

endpackage

[src/baq_ctrl.sv]
module baq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    operation,
  input  baq_pkg::sts_t sts,
  output logic          in_stall,
  output baq_pkg::cmd_t cmd
);
  import baq_pkg::*;

  state_t state, state_next;
  logic   acc;

  assign acc = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (op_t'(operation))
            OP_HEADER: state_next = ST_HDR;
            OP_SAMPLE: state_next = sts.err ? ST_DONE : ST_RD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_HDR:  state_next = ST_IDLE;
      ST_RD:   state_next = ST_DIV;
      ST_DIV:  if (sts.div_last) state_next = ST_DONE;
      ST_DONE: if (sts.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != ST_IDLE);
    cmd          = '0;
    cmd.accept   = acc;
    cmd.hdr_set  = (state == ST_HDR);
    cmd.div_load = (state == ST_RD);
    cmd.div_step = (state == ST_DIV);
    cmd.out_load = (state == ST_DONE) && sts.out_free;
  end

endmodule

[src/baq_dp.sv]
module baq_dp #(
  parameter int REP_HALF_DEPTH = 128,
  parameter int VARIANCE_DEPTH = 256,
  parameter int MAX_BLOCK      = 512,
  parameter int OUT_FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  baq_pkg::cfg_t      cfg,
  input  baq_pkg::cmd_t      cmd,
  input  logic [1:0]         operation,
  input  logic [7:0]         table_index,
  input  logic [23:0]        table_value,
  input  logic [8:0]         var_index,
  input  logic [7:0]         code_i,
  input  logic [7:0]         code_q,
  input  logic               out_stall,
  output baq_pkg::sts_t      sts,
  output logic               out_valid,
  output logic signed [31:0] sample_i,
  output logic signed [31:0] sample_q,
  output logic               last_in_block,
  output logic [1:0]         error_code
);
  import baq_pkg::*;

  localparam int RAW = (REP_HALF_DEPTH > 1) ? $clog2(REP_HALF_DEPTH) : 1;
  localparam int VAW = $clog2(VARIANCE_DEPTH);
  localparam int DW  = REP_W + OUT_FRAC_BITS;
  localparam int CW  = $clog2(DW);
  localparam int QW  = (DW > 33) ? DW : 33;
  localparam logic [QW-1:0] NEG_LIM = QW'(1) << 31;
  localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);

  logic [REP_W-1:0] rep_mem [REP_HALF_DEPTH];
  logic [VAR_W-1:0] var_mem [VARIANCE_DEPTH];

  logic [REP_W-1:0]   rd_i, rd_q;
  logic [VAR_W-1:0]   var_rd;
  logic               bad_p, gain_p;
  logic [SCALE_W-1:0] scale;
  logic               bad;
  logic [8:0]         pos;
  logic               neg_i, neg_q, last_r;
  logic [1:0]         err_r;
  logic [DW-1:0]      dq_i, dq_q;
  logic [SCALE_W-1:0] rem_i, rem_q;
  logic [CW-1:0]      cnt;

  // decode codes into table addresses
  logic [8:0]     ent_i, ent_q;
  logic [RAW-1:0] addr_i, addr_q;
  assign ent_i  = code_entry(code_i, cfg.word_length_mode);
  assign ent_q  = code_entry(code_q, cfg.word_length_mode);
  assign addr_i = ({1'b0, ent_i[7:0]} > 9'(REP_HALF_DEPTH - 1)) ?
                  RAW'(REP_HALF_DEPTH - 1) : ent_i[RAW-1:0];
  assign addr_q = ({1'b0, ent_q[7:0]} > 9'(REP_HALF_DEPTH - 1)) ?
                  RAW'(REP_HALF_DEPTH - 1) : ent_q[RAW-1:0];

  // header index resolution
  logic [8:0] segs, vidx;
  logic       flag, hdr_bad;
  assign segs    = cfg.segment_count_mode ? 9'd256 : 9'd128;
  assign flag    = cfg.low_power_flagging && (var_index >= segs);
  assign vidx    = flag ? (var_index - segs) : var_index;
  assign hdr_bad = (vidx >= segs) || ({1'b0, vidx} >= 10'(VARIANCE_DEPTH));

  // block length and position
  logic [9:0] blen, pos_inc;
  logic       last_now;
  always_comb begin
    unique case (cfg.block_len_sel)
      2'd0:    blen = 10'd128;
      2'd1:    blen = 10'd256;
      default: blen = 10'd512;
    endcase
    if (blen > 10'(MAX_BLOCK)) blen = 10'(MAX_BLOCK);
  end
  assign pos_inc  = {1'b0, pos} + 10'd1;
  assign last_now = pos_inc >= blen;

  logic [1:0] err_now;
  assign err_now = bad ? ERR_BAD_INDEX : ((scale == '0) ? ERR_ZERO_SCALE : ERR_NONE);

  logic is_op;
  always_ff @(posedge clk) begin
    if (cmd.accept && op_t'(operation) == OP_LOAD_REP &&
        {1'b0, table_index} < 9'(REP_HALF_DEPTH))
      rep_mem[table_index[RAW-1:0]] <= table_value[REP_W-1:0];
    if (cmd.accept && op_t'(operation) == OP_LOAD_VAR &&
        {1'b0, table_index} < 9'(VARIANCE_DEPTH))
      var_mem[table_index[VAW-1:0]] <= table_value;
  end

  always_ff @(posedge clk) begin
    rd_i   <= rep_mem[addr_i];
    rd_q   <= rep_mem[addr_q];
    var_rd <= var_mem[vidx[VAW-1:0]];
  end

  assign is_op = cmd.accept && (op_t'(operation) == OP_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= '0;
      bad   <= 1'b0;
      pos   <= '0;
    end else begin
      if (cmd.accept && op_t'(operation) == OP_HEADER) pos <= '0;
      else if (is_op) pos <= last_now ? 9'd0 : pos_inc[8:0];
      if (cmd.hdr_set) begin
        bad   <= bad_p;
        scale <= bad_p ? '0 : (gain_p ? {var_rd, 3'b000} : SCALE_W'(var_rd));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && op_t'(operation) == OP_HEADER) begin
      bad_p  <= hdr_bad;
      gain_p <= flag;
    end
    if (is_op) begin
      neg_i  <= ent_i[8];
      neg_q  <= ent_q[8];
      last_r <= last_now;
      err_r  <= err_now;
    end
  end

  // restoring divider, one quotient bit per lane per cycle
  logic [SCALE_W:0] tr_i, tr_q;
  logic             ge_i, ge_q;
  assign tr_i = {rem_i, dq_i[DW-1]};
  assign tr_q = {rem_q, dq_q[DW-1]};
  assign ge_i = tr_i >= {1'b0, scale};
  assign ge_q = tr_q >= {1'b0, scale};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dq_i  <= {rd_i, {OUT_FRAC_BITS{1'b0}}};
      dq_q  <= {rd_q, {OUT_FRAC_BITS{1'b0}}};
      rem_i <= '0;
      rem_q <= '0;
      cnt   <= '0;
    end else if (cmd.div_step) begin
      rem_i <= ge_i ? SCALE_W'(tr_i - {1'b0, scale}) : tr_i[SCALE_W-1:0];
      rem_q <= ge_q ? SCALE_W'(tr_q - {1'b0, scale}) : tr_q[SCALE_W-1:0];
      dq_i  <= {dq_i[DW-2:0], ge_i};
      dq_q  <= {dq_q[DW-2:0], ge_q};
      cnt   <= cnt + CW'(1);
    end
  end

  function automatic logic [31:0] sat(input logic [DW-1:0] q, input logic neg);
    logic [QW-1:0] m;
    m = QW'(q);
    if (neg) begin
      if (m > NEG_LIM) m = NEG_LIM;
      return 32'(QW'(0) - m);
    end
    if (m > POS_LIM) m = POS_LIM;
    return m[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_i      <= (err_r != ERR_NONE) ? '0 : sat(dq_i, neg_i);
      sample_q      <= (err_r != ERR_NONE) ? '0 : sat(dq_q, neg_q);
      last_in_block <= last_r;
      error_code    <= err_r;
    end
  end

  assign sts.err      = (err_now != ERR_NONE);
  assign sts.div_last = (cnt == CW'(DW - 1));
  assign sts.out_free = !out_valid || !out_stall;

endmodule

[src/baq_block_dequantizer.sv]
// Block adaptive quantization decoder for I/Q sample pairs.
// Input channel (in_valid/in_stall): one transfer per item. Operation 0 and 1
// write the reconstruction half table and the variance table, 2 is a block
// header that picks the block scale, 3 is a sample pair that yields one result.
// Output channel (out_valid/out_stall): one transfer per sample item, with
// sample_i/sample_q in signed Q15.16, last_in_block and error_code.
// Config (cfg_valid/cfg_ready, always ready): write cfg_data to register
// cfg_index; only while the block is idle.
// Steps: a load writes its table when taken; a header reads the variance, then
// updates the scale. A sample goes through table read, divider load, then one
// quotient bit per cycle in the restoring divider, which sets the rate; a
// sample flagged in error skips the divider.
// Items are taken one at a time; in_stall is high while one is in work.
// The result sits in an output register, so a stalled receiver only holds
// the next sample back at its final cycle until the register frees.
// Reset (rst, synchronous): config, scale, error flag and position cleared,
// no output pending. Tables are undefined until loaded.
module baq_block_dequantizer #(
  parameter int REP_HALF_DEPTH = 128,
  parameter int VARIANCE_DEPTH = 256,
  parameter int MAX_BLOCK      = 512,
  parameter int OUT_FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [7:0]         table_index,
  input  logic [23:0]        table_value,
  input  logic [8:0]         var_index,
  input  logic [7:0]         code_i,
  input  logic [7:0]         code_q,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] sample_i,
  output logic signed [31:0] sample_q,
  output logic               last_in_block,
  output logic [1:0]         error_code,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import baq_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WORD_LENGTH: cfg.word_length_mode   <= cfg_data[2:0];
        CFG_BLOCK_SIZE:  cfg.block_len_sel      <= cfg_data[1:0];
        CFG_SEGMENTS:    cfg.segment_count_mode <= cfg_data[0];
        CFG_LOW_POWER:   cfg.low_power_flagging <= cfg_data[0];
        default: ;
      endcase
    end
  end

  baq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  baq_dp #(
    .REP_HALF_DEPTH (REP_HALF_DEPTH),
    .VARIANCE_DEPTH (VARIANCE_DEPTH),
    .MAX_BLOCK      (MAX_BLOCK),
    .OUT_FRAC_BITS  (OUT_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .operation     (operation),
    .table_index   (table_index),
    .table_value   (table_value),
    .var_index     (var_index),
    .code_i        (code_i),
    .code_q        (code_q),
    .out_stall     (out_stall),
    .sts           (sts),
    .out_valid     (out_valid),
    .sample_i      (sample_i),
    .sample_q      (sample_q),
    .last_in_block (last_in_block),
    .error_code    (error_code)
  );

`ifndef SYNTHESIS
  // errored samples carry zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != ERR_NONE) |-> (sample_i == 0) && (sample_q == 0))
    else $error("errored sample with nonzero payload");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_code != 2'd3))
    else $error("undefined error code");

  // a new result never loads over one still stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !cmd.out_load)
    else $error("output overrun");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");
`endif

endmodule
